/* hdl/bls_pkg.sv */
// Shared constants for the line stepper: command codes and the grid limit register.
// No dependencies.
`default_nettype none

package bls_pkg;

    // Command kinds carried in tuser of the input stream
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    // Grid limit register
    localparam int          LIMIT_BITS  = 13;
    localparam logic [12:0] LIMIT_RESET = 13'd1000;

endpackage : bls_pkg

`default_nettype wire

/* hdl/bresenham_line_stepper.sv */
// Bresenham line stepper: a load transaction sets up a line, each pixel transaction
// returns the next pixel. Single module; uses bls_pkg for command codes and limit width.
`default_nettype none

// Takes one command transaction per clock unless the result register is stalled, and
// returns one result per pixel command (none for a load) from the input register
// through the step logic into the result register. The line state (positions, error
// term) is updated in that single step, so consecutive pixel commands run at one per
// clock with no bubble. The output register is refilled in the cycle it is taken, so
// throughput only drops when the sink holds tready low. A load replaces any line in
// progress; the end point is not drawn and stepping stops once the minor coordinate
// reaches grid_limit. grid_limit should only be written while the block is idle.
module bresenham_line_stepper #(
    parameter int COORD_BITS = 12
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    // configuration: grid_limit
    input  wire                                    i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire  [bls_pkg::LIMIT_BITS-1:0]         i_cfg_data,
    // command stream
    input  wire                                    i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata from bit 0: x_start, y_start, x_end, y_end, zero padding
    input  wire  [((4*COORD_BITS+7)/8)*8-1:0]      i_s_tdata,
    // tuser: mode
    input  wire                                    i_s_tuser,
    // pixel stream
    output logic                                   o_m_tvalid,
    input  wire                                    i_m_tready,
    // tdata from bit 0: pixel_x, pixel_y, zero padding
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      o_m_tdata,
    // tuser: valid_res
    output logic                                   o_m_tuser,
    output logic                                   o_m_tlast
);

    localparam int CB      = COORD_BITS;
    localparam int ERR_W   = CB + 2;
    localparam int CMP_W   = ((CB > bls_pkg::LIMIT_BITS) ? CB : bls_pkg::LIMIT_BITS) + 1;
    localparam int OUT_W   = ((2*CB+7)/8)*8;

    // configuration
    logic [bls_pkg::LIMIT_BITS-1:0] r_limit;

    // input register
    logic          r_in_valid;
    logic          r_in_mode;
    logic [CB-1:0] r_in_xs, r_in_ys, r_in_xe, r_in_ye;

    // line state
    logic             r_active, n_active;
    logic             r_steep, n_steep;
    logic [CB-1:0]    r_maj_pos, n_maj_pos;
    logic [CB-1:0]    r_maj_end, n_maj_end;
    logic [CB-1:0]    r_min_pos, n_min_pos;
    logic             r_min_down, n_min_down;
    logic [CB-1:0]    r_span_maj, n_span_maj;
    logic [CB-1:0]    r_span_min, n_span_min;
    logic [ERR_W-1:0] r_err, n_err;

    // result register
    logic          r_out_valid;
    logic          r_out_res;
    logic [CB-1:0] r_out_x, r_out_y;
    logic          r_out_last;

    logic          proceed;
    logic          in_take;

    // load set-up
    logic [CB-1:0] dx, dy, a1, b1, a2, b2, ld_a1, ld_b1, ld_a2, ld_b2;
    logic          steep;

    // pixel step
    logic signed [ERR_W-1:0] e_sub, e_next;
    logic [CB-1:0]           next_minor;
    logic [CB:0]             next_major;
    logic                    is_last;
    logic                    pix_res;
    logic [CB-1:0]           pix_x, pix_y;

    assign o_cfg_ready = 1'b1;

    // A pixel command needs the result register free (or being emptied this cycle)
    assign proceed    = r_in_valid &&
                        ((r_in_mode == bls_pkg::MODE_LOAD) || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || proceed;
    assign in_take    = i_s_tvalid && o_s_tready;

    always_comb begin
        dx    = (r_in_xe >= r_in_xs) ? (r_in_xe - r_in_xs) : (r_in_xs - r_in_xe);
        dy    = (r_in_ye >= r_in_ys) ? (r_in_ye - r_in_ys) : (r_in_ys - r_in_ye);
        steep = dy > dx;
        a1    = steep ? r_in_ys : r_in_xs;
        b1    = steep ? r_in_xs : r_in_ys;
        a2    = steep ? r_in_ye : r_in_xe;
        b2    = steep ? r_in_xe : r_in_ye;
        // order endpoints so the major coordinate rises
        if (a1 > a2) begin
            ld_a1 = a2; ld_b1 = b2; ld_a2 = a1; ld_b2 = b1;
        end else begin
            ld_a1 = a1; ld_b1 = b1; ld_a2 = a2; ld_b2 = b2;
        end
    end

    always_comb begin
        // error term stays within [-2*span_minor, 2*span_major), fits ERR_W signed
        e_sub      = $signed(r_err) - $signed({1'b0, r_span_min, 1'b0});
        next_minor = r_min_pos;
        e_next     = e_sub;
        if (e_sub < 0) begin
            next_minor = r_min_down ? (r_min_pos - 1'b1) : (r_min_pos + 1'b1);
            e_next     = e_sub + $signed({1'b0, r_span_maj, 1'b0});
        end
        next_major = {1'b0, r_maj_pos} + 1'b1;
        is_last    = (next_major >= {1'b0, r_maj_end}) ||
                     (CMP_W'(next_minor) >= CMP_W'(r_limit));
        pix_res    = r_active;
        pix_x      = r_active ? (r_steep ? r_min_pos : r_maj_pos) : '0;
        pix_y      = r_active ? (r_steep ? r_maj_pos : r_min_pos) : '0;
    end

    always_comb begin
        n_active   = r_active;
        n_steep    = r_steep;
        n_maj_pos  = r_maj_pos;
        n_maj_end  = r_maj_end;
        n_min_pos  = r_min_pos;
        n_min_down = r_min_down;
        n_span_maj = r_span_maj;
        n_span_min = r_span_min;
        n_err      = r_err;
        if (proceed) begin
            if (r_in_mode == bls_pkg::MODE_LOAD) begin
                n_steep    = steep;
                n_maj_pos  = ld_a1;
                n_maj_end  = ld_a2;
                n_min_pos  = ld_b1;
                n_min_down = !(ld_b1 < ld_b2);
                n_span_maj = ld_a2 - ld_a1;
                n_span_min = (ld_b2 >= ld_b1) ? (ld_b2 - ld_b1) : (ld_b1 - ld_b2);
                n_err      = ERR_W'(ld_a2 - ld_a1);
                n_active   = (ld_a2 != ld_a1) && (CMP_W'(ld_b1) < CMP_W'(r_limit));
            end else if (r_active) begin
                n_min_pos = next_minor;
                n_maj_pos = next_major[CB-1:0];
                n_err     = e_next;
                if (is_last) begin
                    n_active = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= bls_pkg::LIMIT_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
            r_steep     <= 1'b0;
            r_maj_pos   <= '0;
            r_maj_end   <= '0;
            r_min_pos   <= '0;
            r_min_down  <= 1'b0;
            r_span_maj  <= '0;
            r_span_min  <= '0;
            r_err       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proceed) begin
                r_in_valid <= 1'b0;
            end
            if (proceed && (r_in_mode == bls_pkg::MODE_PIXEL)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            r_active   <= n_active;
            r_steep    <= n_steep;
            r_maj_pos  <= n_maj_pos;
            r_maj_end  <= n_maj_end;
            r_min_pos  <= n_min_pos;
            r_min_down <= n_min_down;
            r_span_maj <= n_span_maj;
            r_span_min <= n_span_min;
            r_err      <= n_err;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode <= i_s_tuser;
            r_in_xs   <= i_s_tdata[0*CB +: CB];
            r_in_ys   <= i_s_tdata[1*CB +: CB];
            r_in_xe   <= i_s_tdata[2*CB +: CB];
            r_in_ye   <= i_s_tdata[3*CB +: CB];
        end
        if (proceed && (r_in_mode == bls_pkg::MODE_PIXEL)) begin
            r_out_res  <= pix_res;
            r_out_x    <= pix_x;
            r_out_y    <= pix_y;
            r_out_last <= r_active && is_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_out_y, r_out_x});
    assign o_m_tuser  = r_out_res;
    assign o_m_tlast  = r_out_last;

endmodule : bresenham_line_stepper

`default_nettype wire
